// File: rtl/qpdec_pkg.sv
`timescale 1ns / 1ps

package qpdec_pkg;

  // Bits per continuation group of a prefix integer
  localparam int unsigned GROUP_BITS = 7;

  // Instruction kinds on the decoder stream
  typedef enum logic [1:0] {
    KIND_SECTION_ACK   = 2'd0,
    KIND_STREAM_CANCEL = 2'd1,
    KIND_INSERT_INC    = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_e;

  // Parser state carried from one word to the next
  typedef struct packed {
    logic        mid;
    kind_e       kind;
    logic [63:0] acc;
    logic [6:0]  shift;
    logic [3:0]  count;
  } parse_state_t;

  // One decoded instruction
  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [3:0]  used;
    status_e     status;
  } result_t;

endpackage

// File: rtl/qpdec_step.sv
`timescale 1ns / 1ps

module qpdec_step #(
  parameter int unsigned MAX_CONT_BYTES = 10,
  parameter int unsigned MAX_SHIFT      = 63
) (
  input  logic [7:0]             byte_i,
  input  qpdec_pkg::parse_state_t cur_i,
  output qpdec_pkg::parse_state_t nxt_o,
  output logic                   emit_o,
  output qpdec_pkg::result_t     res_o
);
  import qpdec_pkg::*;

  localparam logic [3:0] CntLimit   = 4'(MAX_CONT_BYTES);
  localparam logic [6:0] ShiftLimit = 7'(MAX_SHIFT);
  localparam logic [6:0] ShiftStep  = 7'(GROUP_BITS);

  kind_e       first_kind;
  logic        prefix_full;
  logic [63:0] prefix_val;
  logic [3:0]  used;
  logic [70:0] shifted;
  logic [64:0] sum;
  logic        cont_err;
  logic        shift_err;
  logic        lost_err;
  logic        err;

  // First word: kind and prefix value
  always_comb begin
    priority if (byte_i[7]) begin
      first_kind  = KIND_SECTION_ACK;
      prefix_full = &byte_i[6:0];
      prefix_val  = {57'd0, byte_i[6:0]};
    end else if (byte_i[6]) begin
      first_kind  = KIND_STREAM_CANCEL;
      prefix_full = &byte_i[5:0];
      prefix_val  = {58'd0, byte_i[5:0]};
    end else begin
      first_kind  = KIND_INSERT_INC;
      prefix_full = &byte_i[5:0];
      prefix_val  = {58'd0, byte_i[5:0]};
    end
  end

  // Continuation word: shift the group in and check limits
  assign used      = cur_i.count + 4'd1;
  assign shifted   = {64'd0, byte_i[6:0]} << cur_i.shift;
  assign sum       = {1'b0, cur_i.acc} + {1'b0, shifted[63:0]};
  assign cont_err  = cur_i.count > CntLimit;
  assign shift_err = cur_i.shift > ShiftLimit;
  assign lost_err  = |shifted[70:64];
  assign err       = cont_err || shift_err || lost_err || sum[64];

  // Next state and result
  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    res_o  = '{kind: cur_i.kind, value: '0, used: used, status: STATUS_OK};
    if (!cur_i.mid) begin
      if (!prefix_full) begin
        emit_o = 1'b1;
        res_o  = '{kind: first_kind, value: prefix_val, used: 4'd1, status: STATUS_OK};
      end else begin
        nxt_o = '{mid: 1'b1, kind: first_kind, acc: prefix_val, shift: '0, count: 4'd1};
      end
    end else if (err) begin
      emit_o       = 1'b1;
      res_o.status = STATUS_ERR;
      nxt_o        = '0;
    end else if (byte_i[7]) begin
      nxt_o.acc   = sum[63:0];
      nxt_o.shift = cur_i.shift + ShiftStep;
      nxt_o.count = used;
    end else begin
      emit_o      = 1'b1;
      res_o.value = sum[63:0];
      nxt_o       = '0;
    end
  end

endmodule

// File: rtl/qpack_decoder_instruction_parser.sv
`timescale 1ns / 1ps
// Structure: a word is registered at acceptance and its result, if any, is then
// registered in the result register once the output can advance past any stall.
// Throughput: one word per cycle while the result output is not stalled; the parser state update is combinational.
// Reset: asynchronous, active low; clears parser state and both valid flags.

module qpack_decoder_instruction_parser #(
  parameter int unsigned MAX_CONT_BYTES = 10,
  parameter int unsigned MAX_SHIFT      = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] value, [67:64] bytes_used, zero pad
  output logic [2:0]  m_axis_tuser_o    // [1:0] kind, [2] status
);
  import qpdec_pkg::*;

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  logic         out_vld_q;
  result_t      out_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         emit;
  result_t      res;
  logic         advance;

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || advance;

  // Input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Decode of one word against the parser state
  qpdec_step #(
    .MAX_CONT_BYTES(MAX_CONT_BYTES),
    .MAX_SHIFT     (MAX_SHIFT)
  ) u_step (
    .byte_i(in_byte_q),
    .cur_i (state_q),
    .nxt_o (state_d),
    .emit_o(emit),
    .res_o (res)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_vld_q && advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_q.used, out_q.value};
  assign m_axis_tuser_o  = {out_q.status, out_q.kind};

`ifndef SYNTH
  // An error result never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2]) |-> (m_axis_tdata_o[63:0] == 64'd0))
    else $error("error result with nonzero value");

  // A single-word instruction holds only a prefix value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[2] && m_axis_tdata_o[67:64] == 4'd1)
      |-> (m_axis_tdata_o[63:7] == 57'd0))
    else $error("single-word result exceeds prefix range");

  // Word count stays within the continuation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[67:64] != 4'd0 &&
      m_axis_tdata_o[67:64] <= 4'(MAX_CONT_BYTES + 2)))
    else $error("bytes_used out of range");

  // A multi-word result, ok or error, means the parser was mid instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && advance && emit && res.used != 4'd1) |-> state_q.mid)
    else $error("continuation result without pending instruction");
`endif

endmodule

// File: test/tb_qpack_decoder_instruction_parser.sv
`timescale 1ns / 1ps

module tb_qpack_decoder_instruction_parser;
  import qpdec_pkg::*;

  localparam int unsigned MAX_CONT     = 10;
  localparam int unsigned SHIFT_LIMIT  = 63;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_BYTES  = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  // stream bytes waiting to be sent, decoded results still owed by the block
  logic [7:0]  byte_q[$];
  result_t     decoded_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned errors = 0;

  // parser state as the predictor sees it
  bit          pr_mid = 1'b0;
  kind_e       pr_kind = KIND_SECTION_ACK;
  logic [63:0] pr_acc = '0;
  logic [6:0]  pr_shift = '0;
  logic [3:0]  pr_count = '0;

  always #5 clk_i = ~clk_i;

  qpack_decoder_instruction_parser #(
    .MAX_CONT_BYTES(MAX_CONT),
    .MAX_SHIFT     (SHIFT_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  function automatic void clear_parse();
    pr_mid   = 1'b0;
    pr_kind  = KIND_SECTION_ACK;
    pr_acc   = '0;
    pr_shift = '0;
    pr_count = '0;
  endfunction

  // Feed one stream byte through the predicted parser; returns 1 with a result
  function automatic bit parse_byte(input logic [7:0] b, output result_t res);
    kind_e       k;
    logic [63:0] pmax;
    logic [63:0] v;
    logic [63:0] payload;
    logic [63:0] add;
    logic [64:0] sum;
    logic [3:0]  used;
    bit          err;
    res = '0;
    // first byte: kind and prefix width
    if (!pr_mid) begin
      if (b[7]) begin
        k = KIND_SECTION_ACK;
        pmax = 64'd127;
      end else if (b[6]) begin
        k = KIND_STREAM_CANCEL;
        pmax = 64'd63;
      end else begin
        k = KIND_INSERT_INC;
        pmax = 64'd63;
      end
      v = {56'd0, b} & pmax;
      if (v < pmax) begin
        res.kind = k;
        res.value = v;
        res.used = 4'd1;
        res.status = STATUS_OK;
        return 1'b1;
      end
      pr_mid = 1'b1;
      pr_kind = k;
      pr_acc = v;
      pr_shift = '0;
      pr_count = 4'd1;
      return 1'b0;
    end
    // continuation byte
    used = pr_count + 4'd1;
    payload = {57'd0, b[6:0]};
    err = 1'b0;
    if (int'(used) - 1 > int'(MAX_CONT)) begin
      err = 1'b1;
    end else if (pr_shift > SHIFT_LIMIT) begin
      err = 1'b1;
    end else begin
      // bits pushed past bit 63
      if (pr_shift != 0 && (payload >> (64 - int'(pr_shift))) != 0) err = 1'b1;
      add = payload << pr_shift;
      sum = {1'b0, pr_acc} + {1'b0, add};
      if (!err && sum[64]) err = 1'b1;
      if (!err) begin
        pr_acc = sum[63:0];
        pr_shift = pr_shift + 7'd7;
        pr_count = used;
      end
    end
    if (err) begin
      res.kind = pr_kind;
      res.value = '0;
      res.used = used;
      res.status = STATUS_ERR;
      clear_parse();
      return 1'b1;
    end
    if (b[7]) return 1'b0;
    res.kind = pr_kind;
    res.value = pr_acc;
    res.used = used;
    res.status = STATUS_OK;
    clear_parse();
    return 1'b1;
  endfunction

  // Driver: offers queued bytes, predicts on each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= 8'h00;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        if (parse_byte(s_data, res)) decoded_q.push_back(res);
      end
      if (!s_valid || s_axis_tready_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_valid <= 1'b1;
          s_data <= byte_q.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results, drives tready with random or held-off back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %h",
                 m_axis_tdata_o, m_axis_tuser_o);
          errors++;
        end else begin
          exp = decoded_q.pop_front();
          if (m_axis_tuser_o[1:0] !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, m_axis_tuser_o[1:0]);
            errors++;
          end
          if (m_axis_tdata_o[63:0] !== exp.value) begin
            $error("value: expected %h, got %h", exp.value, m_axis_tdata_o[63:0]);
            errors++;
          end
          if (m_axis_tdata_o[67:64] !== exp.used) begin
            $error("bytes_used: expected %0d, got %0d", exp.used, m_axis_tdata_o[67:64]);
            errors++;
          end
          if (m_axis_tuser_o[2] !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, m_axis_tuser_o[2]);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        m_ready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Encode one instruction; truncate drops its final byte
  task automatic push_instr(input kind_e k, input logic [63:0] value, input bit truncate);
    logic [7:0]  head;
    logic [63:0] pmax;
    logic [63:0] rem;
    logic [7:0]  seq[$];
    pmax = (k == KIND_SECTION_ACK) ? 64'd127 : 64'd63;
    head = (k == KIND_SECTION_ACK) ? 8'h80 : (k == KIND_STREAM_CANCEL) ? 8'h40 : 8'h00;
    if (value < pmax) begin
      byte_q.push_back(head | value[7:0]);
      return;
    end
    seq.push_back(head | pmax[7:0]);
    rem = value - pmax;
    while (rem >= 64'd128) begin
      seq.push_back({1'b1, rem[6:0]});
      rem = rem >> 7;
    end
    seq.push_back({1'b0, rem[6:0]});
    if (truncate) void'(seq.pop_back());
    foreach (seq[i]) byte_q.push_back(seq[i]);
  endtask

  // All-ones first byte of a random kind
  function automatic logic [7:0] full_prefix();
    case ($urandom_range(2))
      0: return 8'hFF;
      1: return 8'h7F;
      default: return 8'h3F;
    endcase
  endfunction

  task automatic push_random(input int unsigned n);
    int unsigned pick;
    logic [63:0] v;
    bit all_ones;
    while (byte_q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // well-formed instruction, value of random magnitude
        v = {$urandom, $urandom} >> $urandom_range(63);
        push_instr(kind_e'($urandom_range(2)), v, 1'b0);
      end else if (pick < 65) begin
        byte_q.push_back(8'($urandom_range(255)));
      end else if (pick < 75) begin
        // long run of near-empty continuations
        byte_q.push_back(full_prefix());
        for (int i = 0; i < 8; i++) byte_q.push_back(8'h80 | 8'($urandom_range(1)));
        repeat ($urandom_range(4, 2)) byte_q.push_back(8'h80);
        byte_q.push_back(8'($urandom_range(255)));
      end else if (pick < 88) begin
        // large value pushed toward the 64-bit edge
        all_ones = 1'($urandom_range(1));
        byte_q.push_back(full_prefix());
        for (int i = 0; i < 9; i++) begin
          byte_q.push_back(all_ones ? 8'hFF : (8'h80 | 8'($urandom_range(127))));
        end
        byte_q.push_back(8'($urandom_range(255)));
      end else begin
        // cut short, next instruction lands as continuations
        v = {$urandom, $urandom} >> $urandom_range(60);
        push_instr(kind_e'($urandom_range(2)), v, 1'b1);
      end
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || s_valid || decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idle(input int unsigned src, input int unsigned snk);
    @(posedge clk_i);
    src_idle_pct <= src;
    snk_idle_pct <= snk;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single-byte extremes of each kind
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h3E);
    byte_q.push_back(8'h40);
    byte_q.push_back(8'h7E);
    byte_q.push_back(8'h80);
    byte_q.push_back(8'hFE);
    // largest value, ten continuations
    push_instr(KIND_STREAM_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    // sum passes 2^64-1 on the last group
    byte_q.push_back(8'hFF);
    repeat (9) byte_q.push_back(8'hFF);
    byte_q.push_back(8'h01);
    // too many continuation bytes
    byte_q.push_back(8'h3F);
    repeat (11) byte_q.push_back(8'h80);
    set_idle(32, 65);
    drain();

    push_random(PHASE_BYTES);
    drain();

    set_idle(65, 32);
    push_random(PHASE_BYTES);
    drain();

    // no idling, receiver held off while the sender keeps offering
    set_idle(0, 0);
    hold_req <= 1'b1;
    push_random(PHASE_BYTES);
    drain();

    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d results never arrived", decoded_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
